// ===== rtl/core/tsfp_pkg.sv =====
// ============================================================================
// tsfp_pkg - shared types and constants of the transaction field parser
// Parse phase codes, field kind codes and compact-size markers.
// ============================================================================
package tsfp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_kind;
    typedef logic [63:0] t_word;

    // Field kind codes carried on the result channel
    localparam t_kind KIND_VERSION    = 4'd0;
    localparam t_kind KIND_TIMESTAMP  = 4'd1;
    localparam t_kind KIND_IN_COUNT   = 4'd2;
    localparam t_kind KIND_PREV_HASH  = 4'd3;
    localparam t_kind KIND_OUT_INDEX  = 4'd4;
    localparam t_kind KIND_IN_SLEN    = 4'd5;
    localparam t_kind KIND_IN_SCRIPT  = 4'd6;
    localparam t_kind KIND_SEQUENCE   = 4'd7;
    localparam t_kind KIND_OUT_COUNT  = 4'd8;
    localparam t_kind KIND_VALUE      = 4'd9;
    localparam t_kind KIND_OUT_SLEN   = 4'd10;
    localparam t_kind KIND_OUT_SCRIPT = 4'd11;
    localparam t_kind KIND_LOCK_TIME  = 4'd12;

    // Compact-size prefix bytes
    localparam t_byte CS_MARK_16 = 8'hfd;
    localparam t_byte CS_MARK_32 = 8'hfe;

    localparam logic [5:0] HASH_BYTES   = 6'd32;
    localparam logic [5:0] WORD32_BYTES = 6'd4;
    localparam logic [5:0] WORD64_BYTES = 6'd8;

    typedef enum logic [12:0] {
        PH_VERSION    = 13'b0_0000_0000_0001,
        PH_TIMESTAMP  = 13'b0_0000_0000_0010,
        PH_IN_COUNT   = 13'b0_0000_0000_0100,
        PH_PREV_HASH  = 13'b0_0000_0000_1000,
        PH_OUT_INDEX  = 13'b0_0000_0001_0000,
        PH_IN_SLEN    = 13'b0_0000_0010_0000,
        PH_IN_SCRIPT  = 13'b0_0000_0100_0000,
        PH_SEQUENCE   = 13'b0_0000_1000_0000,
        PH_OUT_COUNT  = 13'b0_0001_0000_0000,
        PH_VALUE      = 13'b0_0010_0000_0000,
        PH_OUT_SLEN   = 13'b0_0100_0000_0000,
        PH_OUT_SCRIPT = 13'b0_1000_0000_0000,
        PH_LOCK_TIME  = 13'b1_0000_0000_0000
    } t_phase;

endpackage

// ===== rtl/core/tsfp_byte_if.sv =====
// ============================================================================
// tsfp_byte_if - byte stream channel
// Valid/ready channel carrying one byte of the serialized transaction.
// ============================================================================
interface tsfp_byte_if;
    logic            valid;
    logic            ready;
    tsfp_pkg::t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/tsfp_field_if.sv =====
// ============================================================================
// tsfp_field_if - field event channel
// Valid/ready channel carrying one decoded field event.
// ============================================================================
interface tsfp_field_if;
    logic            valid;
    logic            ready;
    tsfp_pkg::t_kind field_kind;
    tsfp_pkg::t_word field_value;
    logic            end_of_transaction;

    modport source (output valid, output field_kind, output field_value,
                    output end_of_transaction, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input end_of_transaction, output ready);
endinterface

// ===== rtl/core/tx_stream_field_parser.sv =====
// ============================================================================
// tx_stream_field_parser - byte-serial transaction field parser
// Walks a serialized transaction one byte per item and emits one event per
// completed field (hash and script bytes are events of their own).
// ============================================================================
//
//  channel      dir  payload                                    handshake
//  -----------  ---  -----------------------------------------  -----------
//  i_byte_in    in   data_byte[7:0]                             valid/ready
//  o_field_out  out  field_kind[3:0], field_value[63:0],        valid/ready
//                    end_of_transaction
//
//  Flow: one byte is taken per cycle unless a stall holds it. A byte is
//  held in the input register, is decoded against the parse state and,
//  if it completes a field, is loaded into the result register.
//  Reset: i_rst_n low clears both stages and returns the parser to the
//  version field of a new transaction.
//  Stalls: a held result blocks the input stage only when the byte there
//  would itself produce a result; bytes that complete nothing keep flowing.
// ============================================================================
module tx_stream_field_parser (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tsfp_byte_if.sink    i_byte_in,
    tsfp_field_if.source o_field_out
);
    import tsfp_pkg::*;

    // Input stage
    logic  r_in_vld;
    t_byte r_in_byte;

    // Parse state
    t_phase      r_phase,   n_phase;
    logic [5:0]  r_cnt,     n_cnt;
    t_word       r_acc,     n_acc;
    logic [3:0]  r_csz,     n_csz;
    t_word       r_entries, n_entries;
    t_word       r_script,  n_script;

    // Result stage
    logic  r_out_vld;
    t_kind r_out_kind;
    t_word r_out_value;
    logic  r_out_eot;

    // Decode results
    logic  w_done;
    t_word w_value;
    t_kind w_kind;

    // Shared helpers
    t_word      w_acc_or;
    logic [5:0] w_cnt_inc;
    logic       w_fx4_done;
    logic       w_fx8_done;
    logic       w_cmp_done;
    t_word      w_cmp_value;
    logic [5:0] w_cmp_cnt;
    t_word      w_cmp_acc;
    logic [3:0] w_cmp_csz;
    logic       w_entries_last;
    logic       w_script_last;

    logic w_out_free;
    logic w_adv;

    // ------------------------------------------------------------------
    // Little-endian gather: OR the byte into its lane, count it.
    // ------------------------------------------------------------------
    assign w_acc_or   = r_acc | ({56'd0, r_in_byte} << {r_cnt[2:0], 3'b000});
    assign w_cnt_inc  = r_cnt + 6'd1;
    assign w_fx4_done = (w_cnt_inc >= WORD32_BYTES);
    assign w_fx8_done = (w_cnt_inc >= WORD64_BYTES);

    // "Decrement and test for zero" is the same as "was one".
    assign w_entries_last = (r_entries == 64'd1);
    assign w_script_last  = (r_script  == 64'd1);

    // ------------------------------------------------------------------
    // Compact-size decode, shared by every count and length phase.
    // ------------------------------------------------------------------
    always_comb begin
        w_cmp_done  = 1'b0;
        w_cmp_value = '0;
        w_cmp_cnt   = r_cnt;
        w_cmp_acc   = r_acc;
        w_cmp_csz   = r_csz;
        if (r_csz == 4'd0) begin
            if (r_in_byte < CS_MARK_16) begin
                // Value fits in the prefix byte itself
                w_cmp_done  = 1'b1;
                w_cmp_value = {56'd0, r_in_byte};
            end else begin
                // Prefix: arm a 2, 4 or 8 byte little-endian tail
                w_cmp_cnt = '0;
                w_cmp_acc = '0;
                if (r_in_byte == CS_MARK_16) begin
                    w_cmp_csz = 4'd2;
                end else if (r_in_byte == CS_MARK_32) begin
                    w_cmp_csz = 4'd4;
                end else begin
                    w_cmp_csz = 4'd8;
                end
            end
        end else begin
            w_cmp_acc = w_acc_or;
            w_cmp_cnt = w_cnt_inc;
            if (w_cnt_inc >= {2'b00, r_csz}) begin
                w_cmp_done  = 1'b1;
                w_cmp_value = w_acc_or;
                w_cmp_acc   = '0;
                w_cmp_cnt   = '0;
                w_cmp_csz   = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Phase step for the byte held in the input register.
    // ------------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_csz     = r_csz;
        n_entries = r_entries;
        n_script  = r_script;
        w_done    = 1'b0;
        w_value   = '0;
        w_kind    = KIND_VERSION;

        case (r_phase)
            PH_TIMESTAMP: begin
                w_kind = KIND_TIMESTAMP;
                n_acc  = w_acc_or;
                n_cnt  = w_cnt_inc;
                if (w_fx4_done) begin
                    w_done  = 1'b1;
                    w_value = w_acc_or;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_IN_COUNT;
                end
            end
            PH_IN_COUNT: begin
                w_kind  = KIND_IN_COUNT;
                w_done  = w_cmp_done;
                w_value = w_cmp_value;
                n_acc   = w_cmp_acc;
                n_cnt   = w_cmp_cnt;
                n_csz   = w_cmp_csz;
                if (w_cmp_done) begin
                    n_entries = w_cmp_value;
                    n_phase   = (w_cmp_value == 64'd0) ? PH_OUT_COUNT : PH_PREV_HASH;
                end
            end
            PH_PREV_HASH: begin
                w_kind  = KIND_PREV_HASH;
                w_done  = 1'b1;
                w_value = {56'd0, r_in_byte};
                n_cnt   = w_cnt_inc;
                if (w_cnt_inc >= HASH_BYTES) begin
                    n_cnt   = '0;
                    n_phase = PH_OUT_INDEX;
                end
            end
            PH_OUT_INDEX: begin
                w_kind = KIND_OUT_INDEX;
                n_acc  = w_acc_or;
                n_cnt  = w_cnt_inc;
                if (w_fx4_done) begin
                    w_done  = 1'b1;
                    w_value = w_acc_or;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_IN_SLEN;
                end
            end
            PH_IN_SLEN: begin
                w_kind  = KIND_IN_SLEN;
                w_done  = w_cmp_done;
                w_value = w_cmp_value;
                n_acc   = w_cmp_acc;
                n_cnt   = w_cmp_cnt;
                n_csz   = w_cmp_csz;
                if (w_cmp_done) begin
                    n_script = w_cmp_value;
                    n_phase  = (w_cmp_value == 64'd0) ? PH_SEQUENCE : PH_IN_SCRIPT;
                end
            end
            PH_IN_SCRIPT: begin
                w_kind   = KIND_IN_SCRIPT;
                w_done   = 1'b1;
                w_value  = {56'd0, r_in_byte};
                n_script = r_script - 64'd1;
                if (w_script_last) begin
                    n_phase = PH_SEQUENCE;
                end
            end
            PH_SEQUENCE: begin
                w_kind = KIND_SEQUENCE;
                n_acc  = w_acc_or;
                n_cnt  = w_cnt_inc;
                if (w_fx4_done) begin
                    w_done    = 1'b1;
                    w_value   = w_acc_or;
                    n_acc     = '0;
                    n_cnt     = '0;
                    n_entries = r_entries - 64'd1;
                    n_phase   = w_entries_last ? PH_OUT_COUNT : PH_PREV_HASH;
                end
            end
            PH_OUT_COUNT: begin
                w_kind  = KIND_OUT_COUNT;
                w_done  = w_cmp_done;
                w_value = w_cmp_value;
                n_acc   = w_cmp_acc;
                n_cnt   = w_cmp_cnt;
                n_csz   = w_cmp_csz;
                if (w_cmp_done) begin
                    n_entries = w_cmp_value;
                    n_phase   = (w_cmp_value == 64'd0) ? PH_LOCK_TIME : PH_VALUE;
                end
            end
            PH_VALUE: begin
                w_kind = KIND_VALUE;
                n_acc  = w_acc_or;
                n_cnt  = w_cnt_inc;
                if (w_fx8_done) begin
                    w_done  = 1'b1;
                    w_value = w_acc_or;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_OUT_SLEN;
                end
            end
            PH_OUT_SLEN: begin
                w_kind  = KIND_OUT_SLEN;
                w_done  = w_cmp_done;
                w_value = w_cmp_value;
                n_acc   = w_cmp_acc;
                n_cnt   = w_cmp_cnt;
                n_csz   = w_cmp_csz;
                if (w_cmp_done) begin
                    n_script = w_cmp_value;
                    if (w_cmp_value == 64'd0) begin
                        // Empty script closes the output right here
                        n_entries = r_entries - 64'd1;
                        n_phase   = w_entries_last ? PH_LOCK_TIME : PH_VALUE;
                    end else begin
                        n_phase = PH_OUT_SCRIPT;
                    end
                end
            end
            PH_OUT_SCRIPT: begin
                w_kind   = KIND_OUT_SCRIPT;
                w_done   = 1'b1;
                w_value  = {56'd0, r_in_byte};
                n_script = r_script - 64'd1;
                if (w_script_last) begin
                    n_entries = r_entries - 64'd1;
                    n_phase   = w_entries_last ? PH_LOCK_TIME : PH_VALUE;
                end
            end
            PH_LOCK_TIME: begin
                w_kind = KIND_LOCK_TIME;
                n_acc  = w_acc_or;
                n_cnt  = w_cnt_inc;
                if (w_fx4_done) begin
                    w_done  = 1'b1;
                    w_value = w_acc_or;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_VERSION;
                end
            end
            default: begin
                // Version field; a corrupt phase code restarts here as well
                w_kind  = KIND_VERSION;
                n_acc   = w_acc_or;
                n_cnt   = w_cnt_inc;
                n_phase = PH_VERSION;
                if (w_fx4_done) begin
                    w_done  = 1'b1;
                    w_value = w_acc_or;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_TIMESTAMP;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: advance the held byte unless it needs a result slot
    // that is still occupied.
    // ------------------------------------------------------------------
    assign w_out_free      = !r_out_vld || o_field_out.ready;
    assign w_adv           = r_in_vld && (!w_done || w_out_free);
    assign i_byte_in.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte_in.ready) begin
            r_in_vld <= i_byte_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_in.ready && i_byte_in.valid) begin
            r_in_byte <= i_byte_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_VERSION;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_csz     <= '0;
            r_entries <= '0;
            r_script  <= '0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_csz     <= n_csz;
            r_entries <= n_entries;
            r_script  <= n_script;
        end
    end

    // Result register: load on a completed field, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_done) begin
            r_out_vld <= 1'b1;
        end else if (o_field_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_done) begin
            r_out_kind  <= w_kind;
            r_out_value <= w_value;
            r_out_eot   <= (w_kind == KIND_LOCK_TIME);
        end
    end

    assign o_field_out.valid              = r_out_vld;
    assign o_field_out.field_kind         = r_out_kind;
    assign o_field_out.field_value        = r_out_value;
    assign o_field_out.end_of_transaction = r_out_eot;

endmodule

// ===== rtl/core/tsfp_checker.sv =====
// ============================================================================
// tsfp_checker - port-level checks for the transaction field parser
// Watches the result channel over time and flags inconsistent events.
// ============================================================================
module tsfp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input tsfp_pkg::t_kind i_out_kind,
    input tsfp_pkg::t_word i_out_value,
    input logic            i_out_eot
);
    import tsfp_pkg::*;

    // No event may show up right out of reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // End of transaction is flagged on the lock time and nowhere else
    a_eot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_eot == (i_out_kind == KIND_LOCK_TIME)))
        else $error("end_of_transaction does not match lock time kind");

    // Only defined kinds are emitted
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind <= KIND_LOCK_TIME))
        else $error("undefined field kind");

    // Single-byte events carry just the byte
    a_byte_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == KIND_PREV_HASH || i_out_kind == KIND_IN_SCRIPT
                         || i_out_kind == KIND_OUT_SCRIPT))
        |-> (i_out_value[63:8] == 56'd0))
        else $error("byte event wider than one byte");

    // A stalled event holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_kind) && $stable(i_out_value) && $stable(i_out_eot)))
        else $error("stalled result changed");

endmodule

bind tx_stream_field_parser tsfp_checker u_tsfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_field_out.valid),
    .i_out_ready (o_field_out.ready),
    .i_out_kind  (o_field_out.field_kind),
    .i_out_value (o_field_out.field_value),
    .i_out_eot   (o_field_out.end_of_transaction)
);
